// ----- src/at_rci_pkg.sv -----
// Shared types and constants for the AT register command interpreter.
// No dependencies; the parser, queue, executor, top level and testbench import this package.
package at_rci_pkg;

    // Status codes carried in a result item
    localparam logic [2:0] ST_READ_VALUE   = 3'd0;
    localparam logic [2:0] ST_LIST_QUERY   = 3'd1;
    localparam logic [2:0] ST_OK           = 3'd2;
    localparam logic [2:0] ST_INVALID_IN   = 3'd3;
    localparam logic [2:0] ST_INVALID_CMD  = 3'd4;
    localparam logic [2:0] ST_INVALID_REG  = 3'd5;

    // Widest register index field: covers up to 126 registers plus the overflow mark
    localparam int IDX_FIELD_W = 7;

    // Depth of the command queue between parser and executor
    localparam int CMDQ_DEPTH = 2;

    // Value limits
    localparam logic [31:0] MAG_CAP      = 32'h8000_0000;
    localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] REG2_MAX     = 32'd16555;
    localparam logic [31:0] REG1_MIN     = 32'd1;
    localparam logic [31:0] REG1_MAX     = 32'd3;
    localparam logic [31:0] REG1_RESET   = 32'd1;
    localparam logic [31:0] REG2_RESET   = 32'd1000;

    // Character codes
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Command class decided by the parser
    typedef enum logic [2:0] {
        KIND_READ    = 3'd0,
        KIND_QUERY   = 3'd1,
        KIND_WRITE   = 3'd2,
        KIND_BAD_CMD = 3'd3,
        KIND_BAD_REG = 3'd4
    } t_kind;

    // One parsed command handed from parser to executor
    typedef struct packed {
        t_kind                    kind;
        logic [IDX_FIELD_W-1:0]   reg_idx;
        logic [31:0]              mag;
        logic                     neg;
    } t_cmd;

endpackage

// ----- src/at_rci_if.sv -----
// Valid/ready channel interfaces for characters in and results out.
// Depends on nothing; used by the parser, the executor and the top level.
interface at_rci_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_command;

    modport source (output valid, output char_code, output end_of_command, input ready);
    modport sink   (input valid, input char_code, input end_of_command, output ready);
endinterface

interface at_rci_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [3:0]         reg_number;
    logic signed [31:0] read_value;

    modport source (output valid, output status, output reg_number, output read_value,
                    input ready);
    modport sink   (input valid, input status, input reg_number, input read_value,
                    output ready);
endinterface

// ----- src/at_rci_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module at_rci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/at_rci_parser.sv -----
// Front end: accepts characters, tracks the command form, accumulates index and value.
// Depends on at_rci_pkg and at_rci_in_if; pushes one t_cmd per command.
module at_rci_parser
    import at_rci_pkg::*;
#(
    parameter int NUM_REGS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    at_rci_in_if.sink    i_cmd,
    input  logic         i_q_full,
    output logic         o_push,
    output t_cmd         o_push_cmd
);

    localparam int IW  = $clog2(NUM_REGS + 2);
    localparam int PRW = $clog2(NUM_REGS * 10 + 10);
    localparam logic [PRW-1:0] NREGS_P = PRW'(NUM_REGS);
    localparam logic [IW-1:0]  IDX_OVF = IW'(NUM_REGS + 1);
    localparam logic [IW-1:0]  NREGS_I = IW'(NUM_REGS);

    typedef enum logic [12:0] {
        PH_A         = 13'b0000000000001,
        PH_T         = 13'b0000000000010,
        PH_PLUS      = 13'b0000000000100,
        PH_R         = 13'b0000000001000,
        PH_E         = 13'b0000000010000,
        PH_G         = 13'b0000000100000,
        PH_IDX_FIRST = 13'b0000001000000,
        PH_IDX       = 13'b0000010000000,
        PH_AFTER_EQ  = 13'b0000100000000,
        PH_QUERY     = 13'b0001000000000,
        PH_MINUS     = 13'b0010000000000,
        PH_VAL       = 13'b0100000000000,
        PH_BAD       = 13'b1000000000000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_mag, n_mag;
    logic          r_neg, n_neg;

    logic           accept;
    logic           is_digit;
    logic [3:0]     digit;
    logic [PRW-1:0] idx_prod;
    logic [35:0]    mag_prod;
    logic [IW-1:0]  idx_step;
    logic [31:0]    mag_step;
    t_cmd           cmd;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign is_digit    = (i_cmd.char_code >= CH_ZERO) && (i_cmd.char_code <= CH_NINE);
    assign digit       = i_cmd.char_code[3:0];

    // Saturating decimal accumulation of the index and the value magnitude
    always_comb begin
        idx_prod = (PRW'(r_idx) << 3) + (PRW'(r_idx) << 1) + PRW'(digit);
        if (PRW'(r_idx) > NREGS_P) begin
            idx_step = r_idx;
        end else if (idx_prod > NREGS_P) begin
            idx_step = IDX_OVF;
        end else begin
            idx_step = idx_prod[IW-1:0];
        end

        mag_prod = (36'(r_mag) << 3) + (36'(r_mag) << 1) + 36'(digit);
        if (r_mag >= MAG_CAP) begin
            mag_step = r_mag;
        end else if (mag_prod > 36'(MAG_CAP)) begin
            mag_step = MAG_CAP;
        end else begin
            mag_step = mag_prod[31:0];
        end
    end

    // Next phase and accumulators for the current character
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_mag   = r_mag;
        n_neg   = r_neg;
        unique case (r_phase) inside
            PH_A:    n_phase = (i_cmd.char_code == CH_A)    ? PH_T     : PH_BAD;
            PH_T:    n_phase = (i_cmd.char_code == CH_T)    ? PH_PLUS  : PH_BAD;
            PH_PLUS: n_phase = (i_cmd.char_code == CH_PLUS) ? PH_R     : PH_BAD;
            PH_R:    n_phase = (i_cmd.char_code == CH_R)    ? PH_E     : PH_BAD;
            PH_E:    n_phase = (i_cmd.char_code == CH_E)    ? PH_G     : PH_BAD;
            PH_G:    n_phase = (i_cmd.char_code == CH_G)    ? PH_IDX_FIRST : PH_BAD;
            PH_IDX_FIRST, PH_IDX: begin
                if (is_digit) begin
                    n_idx   = idx_step;
                    n_phase = PH_IDX;
                end else if (i_cmd.char_code == CH_EQ && r_phase == PH_IDX) begin
                    n_phase = PH_AFTER_EQ;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_AFTER_EQ, PH_MINUS, PH_VAL: begin
                if (is_digit) begin
                    n_mag   = mag_step;
                    n_phase = PH_VAL;
                end else if (r_phase == PH_AFTER_EQ && i_cmd.char_code == CH_QMARK) begin
                    n_phase = PH_QUERY;
                end else if (r_phase == PH_AFTER_EQ && i_cmd.char_code == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_MINUS;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            default: n_phase = PH_BAD;
        endcase
    end

    // Classify the finished command
    always_comb begin
        cmd.reg_idx = IDX_FIELD_W'(n_idx);
        cmd.mag     = n_mag;
        cmd.neg     = n_neg;
        if (n_phase != PH_IDX && n_phase != PH_QUERY && n_phase != PH_VAL) begin
            cmd.kind    = KIND_BAD_CMD;
            cmd.reg_idx = '0;
        end else if (n_idx == '0 || n_idx > NREGS_I) begin
            cmd.kind = KIND_BAD_REG;
        end else if (n_phase == PH_IDX) begin
            cmd.kind = KIND_READ;
        end else if (n_phase == PH_QUERY) begin
            cmd.kind = KIND_QUERY;
        end else begin
            cmd.kind = KIND_WRITE;
        end
    end

    assign o_push     = accept && i_cmd.end_of_command;
    assign o_push_cmd = cmd;

    // Advance parse state; restart after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_A;
            r_idx   <= '0;
            r_mag   <= '0;
            r_neg   <= 1'b0;
        end else if (accept) begin
            if (i_cmd.end_of_command) begin
                r_phase <= PH_A;
                r_idx   <= '0;
                r_mag   <= '0;
                r_neg   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
            end
        end
    end

endmodule

// ----- src/at_rci_cmd_queue.sv -----
// Short FIFO of parsed commands between parser and executor.
// Depends on at_rci_pkg for t_cmd and CMDQ_DEPTH.
module at_rci_cmd_queue
    import at_rci_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CMDQ_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(CMDQ_DEPTH - 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/at_rci_exec.sv -----
// Back end: carries out parsed commands on the register file and drives results.
// Depends on at_rci_pkg, at_rci_out_if and at_rci_ram.
module at_rci_exec
    import at_rci_pkg::*;
#(
    parameter int NUM_REGS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_cmd          i_q_head,
    output logic          o_pop,
    at_rci_out_if.source  o_rsp
);

    localparam int IW = $clog2(NUM_REGS + 2);
    localparam int AW = $clog2(NUM_REGS);

    logic [NUM_REGS-1:0] r_written;

    logic          r_s1_valid;
    logic [2:0]    r_s1_status;
    logic [3:0]    r_s1_reg;
    logic          r_s1_read;
    logic          r_s1_hit;
    logic [31:0]   r_s1_dflt;

    logic               r_o_valid;
    logic [2:0]         r_o_status;
    logic [3:0]         r_o_reg;
    logic signed [31:0] r_o_value;

    logic          out_load, s1_ready;
    logic [IW-1:0] idx;
    logic [AW-1:0] addr;
    logic [7:0]    idx_wide;
    logic          neg;
    logic [31:0]   bits;
    logic          ok;
    logic          we, re;
    logic [2:0]    status;
    logic [31:0]   dflt;
    logic [31:0]   rdata;

    assign out_load = !r_o_valid || o_rsp.ready;
    assign s1_ready = !r_s1_valid || out_load;
    assign o_pop    = i_q_valid && s1_ready;

    assign idx      = i_q_head.reg_idx[IW-1:0];
    assign addr     = AW'(idx - IW'(1));
    assign idx_wide = 8'(i_q_head.reg_idx);

    // Signed write value, saturated, and the per-register range check
    always_comb begin
        neg = i_q_head.neg && (i_q_head.mag != '0);
        if (neg) begin
            bits = 32'd0 - i_q_head.mag;
        end else if (i_q_head.mag >= MAG_CAP) begin
            bits = POS_MAX;
        end else begin
            bits = i_q_head.mag;
        end
        if (idx == IW'(1)) begin
            ok = !neg && bits >= REG1_MIN && bits <= REG1_MAX;
        end else if (idx == IW'(2)) begin
            ok = !neg && bits <= REG2_MAX;
        end else begin
            ok = 1'b1;
        end
    end

    // Decode the command class into a status and memory operation
    always_comb begin
        we = 1'b0;
        re = 1'b0;
        unique case (i_q_head.kind)
            KIND_READ: begin
                status = ST_READ_VALUE;
                re     = o_pop;
            end
            KIND_QUERY:   status = ST_LIST_QUERY;
            KIND_WRITE: begin
                status = ok ? ST_OK : ST_INVALID_IN;
                we     = o_pop && ok;
            end
            KIND_BAD_CMD: status = ST_INVALID_CMD;
            KIND_BAD_REG: status = ST_INVALID_REG;
            default:      status = ST_INVALID_CMD;
        endcase
    end

    // Reset contents of a never-written register
    always_comb begin
        if (addr == AW'(0)) begin
            dflt = REG1_RESET;
        end else if (addr == AW'(1)) begin
            dflt = REG2_RESET;
        end else begin
            dflt = '0;
        end
    end

    at_rci_ram #(
        .WIDTH (32),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (bits),
        .i_re    (re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // Mark registers that hold a written value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (we) begin
            r_written[addr] <= 1'b1;
        end
    end

    // Stage 1: command issued, read data pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_status <= status;
            r_s1_reg    <= idx_wide[3:0];
            r_s1_read   <= (i_q_head.kind == KIND_READ);
            r_s1_hit    <= r_written[addr];
            r_s1_dflt   <= dflt;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_o_status <= r_s1_status;
            r_o_reg    <= r_s1_reg;
            if (r_s1_read) begin
                r_o_value <= r_s1_hit ? $signed(rdata) : $signed(r_s1_dflt);
            end else begin
                r_o_value <= '0;
            end
        end
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.reg_number = r_o_reg;
    assign o_rsp.read_value = r_o_value;

endmodule

// ----- src/at_register_command_interpreter.sv -----
// AT register command interpreter: one character accepted per cycle unless the command
// queue is full. A result passes through the queue, the issue/RAM read stage and the
// output register after the last character of its command is accepted.
// Reset restarts parsing and makes registers 1 and 2 read 1 and 1000, all others 0,
// at once; no clearing pass is needed.
module at_register_command_interpreter
    import at_rci_pkg::*;
#(
    parameter int NUM_REGS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    at_rci_in_if.sink    i_cmd,
    at_rci_out_if.source o_rsp
);

    logic q_full, q_valid, push, pop;
    t_cmd push_cmd, head;

    at_rci_parser #(
        .NUM_REGS (NUM_REGS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    at_rci_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_head     (head)
    );

    at_rci_exec #(
        .NUM_REGS (NUM_REGS)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (head),
        .o_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule

// ----- sim/at_register_command_interpreter_tb.sv -----
// Self-checking testbench for the AT register command interpreter.
// Depends on at_rci_pkg, the channel interfaces in at_rci_if and the top level.
`timescale 1ns / 100ps

module at_register_command_interpreter_tb
    import at_rci_pkg::*;
();

    localparam int NUM_REGS     = 8;
    localparam int RANDOM_CHARS = 1100;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_DIR        = 28;

    // Stand-ins for characters that a string literal cannot carry
    localparam logic [7:0] NUL_MARK = 8'h7E;
    localparam logic [7:0] FF_MARK  = 8'h5E;

    typedef enum logic [3:0] {
        P_A, P_T, P_PLUS, P_R, P_E, P_G, P_IDX0, P_IDX, P_EQ, P_QRY, P_NEG, P_VAL, P_BAD
    } t_cmd_phase;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  reg_number;
        logic [31:0] read_value;
    } t_reply;

    typedef struct packed {
        logic        typed;
        logic [2:0]  status;
        logic [3:0]  reg_number;
        logic [31:0] read_value;
    } t_dir_exp;

    localparam t_dir_exp BY_MODEL = '0;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    at_rci_in_if  cmd_if ();
    at_rci_out_if rsp_if ();

    at_register_command_interpreter #(
        .NUM_REGS (NUM_REGS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Interpreter state as seen by the predictor
    t_cmd_phase  phase;
    int unsigned idx_acc;
    logic [31:0] mag_acc;
    logic        neg_acc;
    logic [31:0] reg_file [NUM_REGS];

    t_reply      expected_replies [$];
    logic [7:0]  cmd_chars [$];

    int errors          = 0;
    int replies_checked = 0;
    int chars_sent      = 0;
    int commands_sent   = 0;
    int cycle_count     = 0;
    int hold_requests   = 0;
    int status_seen [6];

    // Directed commands and, where obvious, their replies
    string dir_text [N_DIR] = '{
        "AT+REG1", "AT+REG2", "AT+REG0", "AT+REG9", "AT+REG123", "AT+REG01",
        "AT+REG3=?", "AT+REG0=?", "AT+REG1=3", "AT+REG1=0", "AT+REG1=-2",
        "AT+REG2=16555", "AT+REG2=16556", "AT+REG2=-0", "AT+REG8=99999999999",
        "AT+REG8", "AT+REG7=-2147483648", "AT+REG7", "AT+REG9=5", "AT+REG1=",
        "AT+REG=5", "at+reg1", "AT+REG1 ", "AT+REG~1", "AT+REG1\n", "AT+REG3=--1",
        "^", "AT+REG1"
    };

    t_dir_exp dir_exp [N_DIR] = '{
        '{1'b1, ST_READ_VALUE,  4'd1, 32'd1},
        '{1'b1, ST_READ_VALUE,  4'd2, 32'd1000},
        '{1'b1, ST_INVALID_REG, 4'd0, 32'd0},
        '{1'b1, ST_INVALID_REG, 4'd9, 32'd0},
        BY_MODEL,
        '{1'b1, ST_READ_VALUE,  4'd1, 32'd1},
        '{1'b1, ST_LIST_QUERY,  4'd3, 32'd0},
        '{1'b1, ST_INVALID_REG, 4'd0, 32'd0},
        '{1'b1, ST_OK,          4'd1, 32'd0},
        '{1'b1, ST_INVALID_IN,  4'd1, 32'd0},
        '{1'b1, ST_INVALID_IN,  4'd1, 32'd0},
        '{1'b1, ST_OK,          4'd2, 32'd0},
        '{1'b1, ST_INVALID_IN,  4'd2, 32'd0},
        '{1'b1, ST_OK,          4'd2, 32'd0},
        BY_MODEL,
        '{1'b1, ST_READ_VALUE,  4'd8, 32'h7FFF_FFFF},
        BY_MODEL,
        '{1'b1, ST_READ_VALUE,  4'd7, 32'h8000_0000},
        '{1'b1, ST_INVALID_REG, 4'd9, 32'd0},
        '{1'b1, ST_INVALID_CMD, 4'd0, 32'd0},
        '{1'b1, ST_INVALID_CMD, 4'd0, 32'd0},
        '{1'b1, ST_INVALID_CMD, 4'd0, 32'd0},
        '{1'b1, ST_INVALID_CMD, 4'd0, 32'd0},
        '{1'b1, ST_INVALID_CMD, 4'd0, 32'd0},
        '{1'b1, ST_INVALID_CMD, 4'd0, 32'd0},
        '{1'b1, ST_INVALID_CMD, 4'd0, 32'd0},
        '{1'b1, ST_INVALID_CMD, 4'd0, 32'd0},
        BY_MODEL
    };

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else             return $urandom_range(20, 60);
    endfunction

    function automatic void clear_parse();
        phase   = P_A;
        idx_acc = 0;
        mag_acc = '0;
        neg_acc = 1'b0;
    endfunction

    function automatic void reset_interpreter();
        clear_parse();
        for (int i = 0; i < NUM_REGS; i++) reg_file[i] = '0;
        reg_file[0] = REG1_RESET;
        reg_file[1] = REG2_RESET;
    endfunction

    // Advance the parse by one character; on the last one form the reply
    function automatic bit interpret_char(input logic [7:0] c, input logic last,
                                          output t_reply r);
        logic              is_dig;
        logic [3:0]        d;
        int unsigned       t;
        longint unsigned   m;
        logic              neg;
        logic [31:0]       bits;
        logic              ok;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d      = c[3:0];
        r      = '0;
        case (phase) inside
            P_A:    phase = (c == CH_A)    ? P_T    : P_BAD;
            P_T:    phase = (c == CH_T)    ? P_PLUS : P_BAD;
            P_PLUS: phase = (c == CH_PLUS) ? P_R    : P_BAD;
            P_R:    phase = (c == CH_R)    ? P_E    : P_BAD;
            P_E:    phase = (c == CH_E)    ? P_G    : P_BAD;
            P_G:    phase = (c == CH_G)    ? P_IDX0 : P_BAD;
            P_IDX0, P_IDX: begin
                if (is_dig) begin
                    // Saturate the index one above the last register
                    if (idx_acc <= NUM_REGS) begin
                        t       = idx_acc * 10 + d;
                        idx_acc = (t > NUM_REGS) ? NUM_REGS + 1 : t;
                    end
                    phase = P_IDX;
                end else if (c == CH_EQ && phase == P_IDX) begin
                    phase = P_EQ;
                end else begin
                    phase = P_BAD;
                end
            end
            P_EQ, P_NEG, P_VAL: begin
                if (is_dig) begin
                    // Saturate the magnitude at 2^31
                    if (mag_acc < MAG_CAP) begin
                        m       = mag_acc;
                        m       = m * 10 + d;
                        mag_acc = (m > MAG_CAP) ? MAG_CAP : m[31:0];
                    end
                    phase = P_VAL;
                end else if (phase == P_EQ && c == CH_QMARK) begin
                    phase = P_QRY;
                end else if (phase == P_EQ && c == CH_MINUS) begin
                    neg_acc = 1'b1;
                    phase   = P_NEG;
                end else begin
                    phase = P_BAD;
                end
            end
            default: phase = P_BAD;
        endcase
        if (!last) return 1'b0;

        r.reg_number = idx_acc[3:0];
        if (phase != P_IDX && phase != P_QRY && phase != P_VAL) begin
            r.status     = ST_INVALID_CMD;
            r.reg_number = 4'd0;
        end else if (idx_acc == 0 || idx_acc > NUM_REGS) begin
            r.status = ST_INVALID_REG;
        end else if (phase == P_IDX) begin
            r.status     = ST_READ_VALUE;
            r.read_value = reg_file[idx_acc - 1];
        end else if (phase == P_QRY) begin
            r.status = ST_LIST_QUERY;
        end else begin
            // Minus zero counts as zero; positive overflow clamps
            neg  = neg_acc && (mag_acc != 0);
            bits = neg ? -mag_acc : ((mag_acc >= MAG_CAP) ? POS_MAX : mag_acc);
            if (idx_acc == 1)      ok = !neg && bits >= REG1_MIN && bits <= REG1_MAX;
            else if (idx_acc == 2) ok = !neg && bits <= REG2_MAX;
            else                   ok = 1'b1;
            if (ok) begin
                reg_file[idx_acc - 1] = bits;
                r.status = ST_OK;
            end else begin
                r.status = ST_INVALID_IN;
            end
        end
        clear_parse();
        return 1'b1;
    endfunction

    // Command text builders
    task automatic add_text(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c == NUL_MARK)     c = 8'h00;
            else if (c == FF_MARK) c = 8'hFF;
            cmd_chars.push_back(c);
        end
    endtask

    task automatic add_number(input longint unsigned n, input bit zero_pad);
        string s;
        s = $sformatf("%0d", n);
        if (zero_pad) repeat ($urandom_range(1, 3)) cmd_chars.push_back(CH_ZERO);
        add_text(s);
    endtask

    task automatic build_wellformed();
        int r;
        int form;
        longint unsigned idx;
        longint unsigned v;
        cmd_chars.delete();
        add_text("AT+REG");
        r = $urandom_range(0, 99);
        if (r < 80)      idx = $urandom_range(1, NUM_REGS);
        else if (r < 88) idx = 0;
        else if (r < 94) idx = $urandom_range(NUM_REGS + 1, 99);
        else             idx = $urandom_range(100, 99999);
        add_number(idx, $urandom_range(0, 7) == 0);
        form = $urandom_range(0, 9);
        if (form == 3) begin
            add_text("=?");
        end else if (form > 3) begin
            add_text("=");
            if ($urandom_range(0, 3) == 0) add_text("-");
            r = $urandom_range(0, 99);
            if (r < 90) begin
                if (r < 25)      v = $urandom_range(0, 5);
                else if (r < 40) v = $urandom_range(16550, 16560);
                else if (r < 55) v = $urandom_range(0, 20000);
                else if (r < 80) v = $urandom;
                else             v = 64'd2147483640 + $urandom_range(0, 20);
                add_number(v, $urandom_range(0, 9) == 0);
            end else begin
                // Far past the 32-bit range
                repeat ($urandom_range(11, 14))
                    cmd_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    task automatic build_noise();
        case ($urandom_range(0, 2))
            0: begin
                cmd_chars.delete();
                repeat ($urandom_range(1, 12)) cmd_chars.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
                build_wellformed();
                cmd_chars[$urandom_range(0, cmd_chars.size() - 1)] = 8'($urandom_range(0, 255));
            end
            default: begin
                build_wellformed();
                repeat ($urandom_range(1, cmd_chars.size() - 1)) void'(cmd_chars.pop_back());
            end
        endcase
    endtask

    // Offer each character until taken; flag the last one as end of command
    task automatic send_command(input bit no_gaps, input t_dir_exp typed_exp);
        t_reply pred;
        logic   last;
        int     g;
        for (int i = 0; i < cmd_chars.size(); i++) begin
            last = (i == cmd_chars.size() - 1);
            cmd_if.valid          <= 1'b1;
            cmd_if.char_code      <= cmd_chars[i];
            cmd_if.end_of_command <= last;
            do @(posedge i_clk); while (!cmd_if.ready);
            chars_sent++;
            if (interpret_char(cmd_chars[i], last, pred)) begin
                commands_sent++;
                if (typed_exp.typed)
                    expected_replies.push_back(t_reply'{typed_exp.status,
                        typed_exp.reg_number, typed_exp.read_value});
                else
                    expected_replies.push_back(pred);
            end
            g = no_gaps ? 0 : pick_gap();
            if (g > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    // Compare one reply with the oldest expectation
    task automatic check_reply();
        t_reply want;
        if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply: expected none, got status %0d reg %0d value %0d",
                     $time, rsp_if.status, rsp_if.reg_number, rsp_if.read_value);
            errors++;
        end else begin
            want = expected_replies.pop_front();
            replies_checked++;
            if (rsp_if.status < 6) status_seen[rsp_if.status]++;
            if (rsp_if.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, rsp_if.status);
                errors++;
            end
            if (rsp_if.reg_number !== want.reg_number) begin
                $display("%0t: reg_number mismatch: expected %0d, got %0d",
                         $time, want.reg_number, rsp_if.reg_number);
                errors++;
            end
            if (rsp_if.read_value !== want.read_value) begin
                $display("%0t: read_value mismatch: expected %0d, got %0d",
                         $time, $signed(want.read_value), rsp_if.read_value);
                errors++;
            end
        end
    endtask

    // Reply side: check taken items, then choose ready with stalls and hold-offs
    initial begin : reply_sink
        int stall_left;
        int hold_left;
        int calm_left;
        int hold_served;
        stall_left  = 0;
        hold_left   = 0;
        calm_left   = 0;
        hold_served = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) check_reply();
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 59) == 0)
                    calm_left = $urandom_range(50, 150);
                else
                    stall_left = pick_gap();
            end
        end
    end

    // Command side: reset, directed table, random commands, drain
    initial begin : command_source
        int  cmd_no;
        int  dir_chars;
        bit  quiet;
        cmd_if.valid          <= 1'b0;
        cmd_if.char_code      <= 8'h00;
        cmd_if.end_of_command <= 1'b0;
        for (int i = 0; i < 6; i++) status_seen[i] = 0;
        reset_interpreter();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < N_DIR; i++) begin
            cmd_chars.delete();
            add_text(dir_text[i]);
            send_command(1'b0, dir_exp[i]);
        end
        wait_drained();
        dir_chars = chars_sent;

        // Random commands, mostly well formed; stall the reply side once, drain once
        cmd_no = 0;
        while (chars_sent - dir_chars < RANDOM_CHARS) begin
            if ($urandom_range(0, 99) < 80) build_wellformed();
            else                            build_noise();
            if (cmd_no == 40) hold_requests <= hold_requests + 1;
            if (cmd_no == 90) wait_drained();
            quiet = (cmd_no >= 40 && cmd_no < 70) || ($urandom_range(0, 9) == 0);
            send_command(quiet, BY_MODEL);
            cmd_no++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d characters in %0d commands; checked %0d replies, %0d errors",
                 chars_sent, commands_sent, replies_checked, errors);
        $display("Replies by status: read %0d, query %0d, ok %0d, bad input %0d, %s %0d, %s %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 "bad command", status_seen[4], "bad register", status_seen[5]);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/at_rci_pkg.sv
src/at_rci_if.sv
src/at_rci_ram.sv
src/at_rci_parser.sv
src/at_rci_cmd_queue.sv
src/at_rci_exec.sv
src/at_register_command_interpreter.sv
sim/at_register_command_interpreter_tb.sv
